/* rtl/acars_ffp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ACARS frame field parser package
// Shared field tags, status codes, character constants and the result type.
// ----------------------------------------------------------------------------
package acars_ffp_pkg;

    localparam int unsigned MIN_FRAME_LEN = 16;

    localparam logic [4:0] POS_MAX   = 5'd31;
    localparam logic [4:0] POS_MODE  = 5'd0;
    localparam logic [4:0] POS_REG_E = 5'd7;
    localparam logic [4:0] POS_ACK   = 5'd8;
    localparam logic [4:0] POS_LBL0  = 5'd9;
    localparam logic [4:0] POS_LBL1  = 5'd10;
    localparam logic [4:0] POS_BLK   = 5'd11;
    localparam logic [4:0] POS_TXT   = 5'd12;
    localparam logic [4:0] POS_MSG0  = 5'd13;
    localparam logic [4:0] POS_MSG_E = 5'd16;
    localparam logic [4:0] POS_FLT0  = 5'd17;
    localparam logic [4:0] POS_FLT_E = 5'd22;
    localparam logic [4:0] POS_ONE   = 5'd1;

    localparam logic [3:0] TAG_MODE   = 4'd0;
    localparam logic [3:0] TAG_REG    = 4'd1;
    localparam logic [3:0] TAG_ACK    = 4'd2;
    localparam logic [3:0] TAG_LABEL  = 4'd3;
    localparam logic [3:0] TAG_BLOCK  = 4'd4;
    localparam logic [3:0] TAG_TXTST  = 4'd5;
    localparam logic [3:0] TAG_MSGNO  = 4'd6;
    localparam logic [3:0] TAG_FLIGHT = 4'd7;
    localparam logic [3:0] TAG_TEXT   = 4'd8;
    localparam logic [3:0] TAG_STATUS = 4'd9;

    localparam logic [6:0] CH_ETX   = 7'h03;
    localparam logic [6:0] CH_NAK   = 7'h15;
    localparam logic [6:0] CH_DEL   = 7'h7f;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_BANG  = 7'h21;
    localparam logic [6:0] CH_LC_D  = 7'h64;
    localparam logic [6:0] CH_UC_Z  = 7'h5a;
    localparam logic [6:0] CH_NINE  = 7'h39;
    localparam logic [6:0] CH_NUL   = 7'h00;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SHORT  = 2'd1,
        ST_NO_DEL = 2'd2
    } t_status;

    typedef struct packed {
        logic [3:0] tag;
        logic [2:0] index;
        logic [6:0] ch;
        t_status    status;
        logic       done;
    } t_result;

endpackage
`default_nettype wire

/* rtl/acars_ffp_classify.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ACARS frame field classifier
// Tags one parity-stripped character by its frame position, applies the
// acknowledge, label and block id substitutions and updates header context.
// ----------------------------------------------------------------------------
module acars_ffp_classify
    import acars_ffp_pkg::*;
(
    input  wire logic [6:0] i_char,
    input  wire logic [4:0] i_pos,
    input  wire logic [6:0] i_mode_char,
    input  wire logic [6:0] i_block_char,
    input  wire logic       i_text_empty,
    output t_result         o_item,
    output logic            o_item_vld,
    output logic [6:0]      o_mode_char,
    output logic [6:0]      o_block_char,
    output logic            o_text_empty
);

    logic [4:0] pos_m1;
    logic [4:0] pos_m13;
    logic [4:0] pos_m17;
    logic       has_msgno;

    assign pos_m1    = i_pos - POS_ONE;
    assign pos_m13   = i_pos - POS_MSG0;
    assign pos_m17   = i_pos - POS_FLT0;
    assign has_msgno = (i_mode_char <= CH_UC_Z) && (i_block_char <= CH_NINE)
                       && (i_pos <= POS_FLT_E);

    always_comb begin
        o_item       = '{tag: TAG_TEXT, index: 3'd0, ch: i_char, status: ST_OK, done: 1'b0};
        o_item_vld   = 1'b1;
        o_mode_char  = i_mode_char;
        o_block_char = i_block_char;
        o_text_empty = i_text_empty;

        if (i_pos == POS_MODE) begin
            o_mode_char = i_char;
            o_item.tag  = TAG_MODE;
        end else if (i_pos <= POS_REG_E) begin
            o_item.tag   = TAG_REG;
            o_item.index = pos_m1[2:0];
        end else if (i_pos == POS_ACK) begin
            o_item.tag = TAG_ACK;
            if (i_char == CH_NAK) begin
                o_item.ch = CH_BANG;
            end
        end else if (i_pos == POS_LBL0) begin
            o_item.tag = TAG_LABEL;
        end else if (i_pos == POS_LBL1) begin
            o_item.tag   = TAG_LABEL;
            o_item.index = 3'd1;
            if (i_char == CH_DEL) begin
                o_item.ch = CH_LC_D;
            end
        end else if (i_pos == POS_BLK) begin
            o_item.tag = TAG_BLOCK;
            if (i_char == CH_NUL) begin
                o_item.ch = CH_SPACE;
            end
            o_block_char = o_item.ch;
        end else if (i_pos == POS_TXT) begin
            o_item.tag   = TAG_TXTST;
            o_text_empty = (i_char == CH_ETX);
        end else if (i_text_empty) begin
            // empty text: drop everything after text start
            o_item_vld = 1'b0;
        end else if (has_msgno) begin
            if (i_pos <= POS_MSG_E) begin
                o_item.tag   = TAG_MSGNO;
                o_item.index = pos_m13[2:0];
            end else begin
                o_item.tag   = TAG_FLIGHT;
                o_item.index = pos_m17[2:0];
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/acars_ffp_outq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ACARS frame field parser result queue
// Four-entry result buffer that takes up to two results per cycle and hands
// out one per transfer.
// ----------------------------------------------------------------------------
module acars_ffp_outq
    import acars_ffp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_wr0,
    input  wire logic    i_wr1,
    input  wire t_result i_item0,
    input  wire t_result i_item1,
    output logic         o_room2,
    output logic         o_valid,
    input  wire logic    i_pop,
    output t_result      o_item
);

    t_result    r_q [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic [1:0] n_wp;
    logic [1:0] n_rp;
    logic [2:0] n_cnt;
    logic [1:0] wp1;
    logic       pop;

    assign o_valid = (r_cnt != 3'd0);
    assign o_room2 = (r_cnt <= 3'd2);
    assign o_item  = r_q[r_rp];
    assign pop     = i_pop && o_valid;
    assign wp1     = r_wp + 2'd1;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_wr0) begin
            n_wp  = wp1;
            n_cnt = n_cnt + 3'd1;
            if (i_wr1) begin
                n_wp  = r_wp + 2'd2;
                n_cnt = n_cnt + 3'd1;
            end
        end
        if (pop) begin
            n_rp  = r_rp + 2'd1;
            n_cnt = n_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr0) begin
            r_q[r_wp] <= i_item0;
        end
        if (i_wr0 && i_wr1) begin
            r_q[wp1] <= i_item1;
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result queue count above depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd0 || r_cnt == 3'd4) |-> (r_wp == r_rp))
        else $error("result queue pointers disagree with count");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr0 && i_wr1 && !pop) |-> o_room2)
        else $error("result queue written past capacity");

endmodule
`default_nettype wire

/* rtl/acars_frame_field_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ACARS frame field parser
// Strips parity, tags header fields, splits message number and flight id,
// removes the CRC/ETX/DEL trailer and closes each frame with a status result.
// ----------------------------------------------------------------------------
// Accepts one frame byte per clock. Each transfer is handled in the cycle it
// is taken: the oldest character of the four-entry trailer delay line is
// tagged and written to a four-entry result queue, where each result is
// registered before o_valid shows it. The final byte of a frame (i_is_last)
// yields up to two results, the last character and the status item, which
// drain over two output transfers; o_ready stays high while the queue has
// room for two results, so with the output side always ready the input is
// never stalled. A status other than ok means the characters already
// delivered for that frame should be discarded.
// ----------------------------------------------------------------------------
module acars_frame_field_parser
    import acars_ffp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_is_last,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [3:0]      o_field_tag,
    output logic [2:0]      o_field_index,
    output logic [6:0]      o_char_value,
    output logic [1:0]      o_frame_status,
    output logic            o_frame_done
);

    logic [4:0] r_pos;
    logic [6:0] r_mode;
    logic [6:0] r_block;
    logic       r_empty;
    logic [2:0] r_fill;
    logic [6:0] r_dly [4];

    logic [4:0] n_pos;
    logic [6:0] n_mode;
    logic [6:0] n_block;
    logic       n_empty;
    logic [2:0] n_fill;
    logic [6:0] n_dly [4];

    logic       accept;
    logic       shift;
    logic [2:0] fill_s;
    logic [4:0] pos_s;
    logic [5:0] total;
    t_result    chr_item;
    logic       chr_vld;
    logic [6:0] cls_mode;
    logic [6:0] cls_block;
    logic       cls_empty;
    t_result    st_item;
    t_result    q_item0;
    logic       q_wr0;
    logic       q_wr1;
    logic       q_room2;
    t_result    q_out;

    assign accept = i_valid && o_ready;
    assign o_ready = q_room2;
    assign shift  = r_fill[2];

    acars_ffp_classify u_classify (
        .i_char       (r_dly[0]),
        .i_pos        (r_pos),
        .i_mode_char  (r_mode),
        .i_block_char (r_block),
        .i_text_empty (r_empty),
        .o_item       (chr_item),
        .o_item_vld   (chr_vld),
        .o_mode_char  (cls_mode),
        .o_block_char (cls_block),
        .o_text_empty (cls_empty)
    );

    always_comb begin
        fill_s = shift ? 3'd3 : r_fill;
        pos_s  = r_pos;
        if (shift && (r_pos < POS_MAX)) begin
            pos_s = r_pos + 5'd1;
        end
        total = {1'b0, pos_s} + {3'd0, fill_s} + 6'd1;

        st_item = '{tag: TAG_STATUS, index: 3'd0, ch: CH_NUL, status: ST_OK, done: 1'b1};
        if (total < 6'(MIN_FRAME_LEN)) begin
            st_item.status = ST_SHORT;
        end else if (i_data_byte != {1'b0, CH_DEL}) begin
            st_item.status = ST_NO_DEL;
        end

        // pack the character result first, status behind it
        q_wr0   = accept && ((shift && chr_vld) || i_is_last);
        q_wr1   = accept && shift && chr_vld && i_is_last;
        q_item0 = (shift && chr_vld) ? chr_item : st_item;
    end

    always_comb begin
        n_pos   = r_pos;
        n_mode  = r_mode;
        n_block = r_block;
        n_empty = r_empty;
        n_fill  = r_fill;
        n_dly   = r_dly;
        if (accept) begin
            if (shift) begin
                n_dly[0] = r_dly[1];
                n_dly[1] = r_dly[2];
                n_dly[2] = r_dly[3];
                n_pos    = pos_s;
                n_mode   = cls_mode;
                n_block  = cls_block;
                n_empty  = cls_empty;
            end
            if (i_is_last) begin
                // frame closed: return to the start-of-frame state
                n_pos   = 5'd0;
                n_mode  = CH_NUL;
                n_block = CH_NUL;
                n_empty = 1'b0;
                n_fill  = 3'd0;
            end else begin
                n_dly[fill_s[1:0]] = i_data_byte[6:0];
                n_fill             = fill_s + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 5'd0;
            r_mode  <= CH_NUL;
            r_block <= CH_NUL;
            r_empty <= 1'b0;
            r_fill  <= 3'd0;
        end else begin
            r_pos   <= n_pos;
            r_mode  <= n_mode;
            r_block <= n_block;
            r_empty <= n_empty;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dly <= n_dly;
    end

    acars_ffp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr0   (q_wr0),
        .i_wr1   (q_wr1),
        .i_item0 (q_item0),
        .i_item1 (st_item),
        .o_room2 (q_room2),
        .o_valid (o_valid),
        .i_pop   (i_ready),
        .o_item  (q_out)
    );

    assign o_field_tag    = q_out.tag;
    assign o_field_index  = q_out.index;
    assign o_char_value   = q_out.ch;
    assign o_frame_status = q_out.status;
    assign o_frame_done   = q_out.done;

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 3'd4)
        else $error("delay line fill above four");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_is_last) |=> (r_fill == 3'd0 && r_pos == 5'd0 && !r_empty))
        else $error("state not cleared after final byte");

    a_steady_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_is_last && r_fill == 3'd4) |=> (r_fill == 3'd4))
        else $error("full delay line lost an entry");

    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done) |-> (o_field_tag == TAG_STATUS && o_char_value == CH_NUL))
        else $error("status result carries character fields");

endmodule
`default_nettype wire
